>>> hdl/m4i_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_pkg
// shared types and constants for the gauss-jordan 4x4 matrix inverse unit
// ----------------------------------------------------------------------------
package m4i_pkg;

    localparam int DIMENSION_DEF     = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_W           = 32;
    localparam int INDEX_W           = 4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic [INDEX_W-1:0]        element_index;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] inverse_value;
        logic [INDEX_W-1:0]        inverse_index;
        logic                      last_element;
        logic                      singular;
    } t_out_item;

    typedef enum logic {
        OP_DIV,
        OP_MULSUB
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_req;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_DIV_FIN,
        A_MUL1,
        A_MUL2,
        A_SUB
    } t_arith_state;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_NRM_RD,
        ST_NRM_W,
        ST_NRM_W_WT,
        ST_NRM_I,
        ST_NRM_I_WT,
        ST_ELIM_SEL,
        ST_ELIM_F,
        ST_ELIM_RD,
        ST_ELIM_W,
        ST_ELIM_W_WT,
        ST_ELIM_I,
        ST_ELIM_I_WT,
        ST_OUT_RD,
        ST_OUT
    } t_seq_state;

endpackage
`default_nettype wire

>>> hdl/m4i_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_arith
// shared fixed-point unit: restoring divide, multiply-subtract, saturation
// ----------------------------------------------------------------------------
module m4i_arith #(
    parameter int FRACTION_BITS = m4i_pkg::FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  m4i_pkg::t_arith_req  i_req,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  logic [31:0]          i_f,
    output logic                 o_done,
    output logic [31:0]          o_result
);
    import m4i_pkg::*;

    localparam int QW = VALUE_W + FRACTION_BITS;
    localparam int CW = $clog2(QW + 1);

    t_arith_state        r_state, n_state;
    logic [VALUE_W-1:0]  r_a, r_b, r_f;
    logic [QW-1:0]       r_num, r_q;
    logic [VALUE_W-1:0]  r_rem, r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_neg;
    logic signed [63:0]  r_prod;
    logic [VALUE_W-1:0]  r_t, r_res;
    logic                r_done;

    logic [VALUE_W:0]    trial;
    logic                fits;
    logic [63:0]         prod_mag;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // clamp a magnitude with sign into the signed 32-bit range
    function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000) return 32'h8000_0000;
            return ~m[31:0] + 32'd1;
        end
        if (m > 64'h0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] t);
        logic [32:0] d;
        d = {a[31], a} - {t[31], t};
        if (d[32] != d[31]) return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return d[31:0];
    endfunction

    assign trial    = {r_rem, r_num[QW-1]};
    assign fits     = trial >= {1'b0, r_den};
    assign prod_mag = r_prod[63] ? (~r_prod + 64'sd1) : r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) n_state = (i_req.op == OP_DIV) ? A_DIV : A_MUL1;
            end
            A_DIV: begin
                if (r_cnt == CW'(QW - 1)) n_state = A_DIV_FIN;
            end
            A_DIV_FIN: n_state = A_IDLE;
            A_MUL1:    n_state = A_MUL2;
            A_MUL2:    n_state = A_SUB;
            A_SUB:     n_state = A_IDLE;
            default:   n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == A_DIV_FIN) || (r_state == A_SUB);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_f   <= i_f;
                    r_num <= {mag32(i_a), FRACTION_BITS'(0)};
                    r_den <= mag32(i_b);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_neg <= i_a[31] ^ i_b[31];
                end
            end
            A_DIV: begin
                r_num <= r_num << 1;
                r_q   <= {r_q[QW-2:0], fits};
                r_rem <= fits ? VALUE_W'(trial - {1'b0, r_den}) : trial[VALUE_W-1:0];
                r_cnt <= r_cnt + CW'(1);
            end
            A_DIV_FIN: r_res  <= sat_mag(64'(r_q), r_neg);
            A_MUL1:    r_prod <= $signed(r_b) * $signed(r_f);
            A_MUL2:    r_t    <= sat_mag(prod_mag >> FRACTION_BITS, r_prod[63]);
            A_SUB:     r_res  <= sub_sat(r_a, r_t);
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == A_IDLE)
        else $error("arith start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done longer than one cycle");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV) && (r_cnt != '0) |-> r_rem < r_den)
        else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

>>> hdl/matrix4_inverse_gauss_jordan_unit.sv
// compute: 32 restoring divides dominate, plus 96 multiply-subtracts, when no pivot is zero
// a zero-pivot column is skipped after its pivot check
// throughput: one matrix at a time; load until the item with index 15, compute, 16 result transactions
// each result is an inverse memory read, then present, held while the output stalls
// reset: synchronous active low, sequencer returns to load, singular flag cleared
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_inverse_gauss_jordan_unit
// 4x4 matrix inverse by gauss-jordan elimination without pivoting, q16.16
// ----------------------------------------------------------------------------
module matrix4_inverse_gauss_jordan_unit #(
    parameter int DIMENSION     = m4i_pkg::DIMENSION_DEF,
    parameter int FRACTION_BITS = m4i_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  m4i_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output m4i_pkg::t_out_item  o_out_data
);
    import m4i_pkg::*;

    localparam int CELLS = DIMENSION * DIMENSION;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(DIMENSION);
    localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1) << FRACTION_BITS;

    // sequencer state and loop counters: column, row, element within row, cell
    t_seq_state        r_state, n_state;
    logic [DW-1:0]     r_c, n_c, r_r, n_r, r_k, n_k;
    logic [AW-1:0]     r_i, n_i;
    logic              r_zero;

    // pivot, row factor and the normalized pivot row of both matrices
    logic [VALUE_W-1:0] r_piv, r_f;
    logic [VALUE_W-1:0] r_prow_w [DIMENSION];
    logic [VALUE_W-1:0] r_prow_i [DIMENSION];

    // source, working and inverse memories with registered reads
    logic [VALUE_W-1:0] r_src_mem [CELLS];
    logic [VALUE_W-1:0] r_w_mem   [CELLS];
    logic [VALUE_W-1:0] r_inv_mem [CELLS];
    logic [VALUE_W-1:0] r_src_rd, r_w_rd, r_inv_rd;

    logic               src_we, src_re, work_re, w_we, inv_we;
    logic [AW-1:0]      src_waddr, work_addr;
    logic [VALUE_W-1:0] w_wdata, inv_wdata;
    logic               accept_in, idx_in_range, idx_final;

    // shared arithmetic unit
    t_arith_req         req;
    logic [VALUE_W-1:0] arith_a, arith_b, arith_res;
    logic               arith_done;

    function automatic logic [AW-1:0] addr_of(input logic [DW-1:0] row,
                                              input logic [DW-1:0] col);
        return AW'(row) * AW'(DIMENSION) + AW'(col);
    endfunction

    assign accept_in    = i_in_valid && !o_in_stall;
    assign idx_in_range = 32'(i_in_data.element_index) < 32'(CELLS);
    assign idx_final    = 32'(i_in_data.element_index) == 32'(CELLS - 1);
    assign src_waddr    = AW'(i_in_data.element_index);

    m4i_arith #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_a      (arith_a),
        .i_b      (arith_b),
        .i_f      (r_f),
        .o_done   (arith_done),
        .o_result (arith_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_c     <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_r     <= n_r;
            r_k     <= n_k;
            r_i     <= n_i;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_r        = r_r;
        n_k        = r_k;
        n_i        = r_i;
        src_we     = 1'b0;
        src_re     = 1'b0;
        work_addr  = addr_of(r_r, r_k);
        work_re    = 1'b0;
        w_we       = 1'b0;
        inv_we     = 1'b0;
        w_wdata    = arith_res;
        inv_wdata  = arith_res;
        req        = '{start: 1'b0, op: OP_DIV};
        arith_a    = r_w_rd;
        arith_b    = r_piv;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;

        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    src_we = idx_in_range;
                    if (idx_final) begin
                        n_state = ST_COPY_RD;
                        n_i     = '0;
                        n_r     = '0;
                        n_k     = '0;
                    end
                end
            end
            // copy the source into the working matrix, inverse set to identity
            ST_COPY_RD: begin
                src_re  = 1'b1;
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                work_addr = r_i;
                w_we      = 1'b1;
                w_wdata   = r_src_rd;
                inv_we    = 1'b1;
                inv_wdata = (r_r == r_k) ? ONE : '0;
                if (r_i == AW'(CELLS - 1)) begin
                    n_state = ST_PIV_RD;
                    n_c     = '0;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = ST_COPY_RD;
                    if (r_k == DW'(DIMENSION - 1)) begin
                        n_k = '0;
                        n_r = r_r + DW'(1);
                    end else begin
                        n_k = r_k + DW'(1);
                    end
                end
            end
            ST_PIV_RD: begin
                work_addr = addr_of(r_c, r_c);
                work_re   = 1'b1;
                n_state   = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                if (r_w_rd == '0) begin
                    // zero pivot: column skipped
                    if (r_c == DW'(DIMENSION - 1)) begin
                        n_state = ST_OUT_RD;
                        n_i     = '0;
                    end else begin
                        n_c     = r_c + DW'(1);
                        n_state = ST_PIV_RD;
                    end
                end else begin
                    n_k     = '0;
                    n_state = ST_NRM_RD;
                end
            end
            // normalize pivot row of both matrices
            ST_NRM_RD: begin
                work_addr = addr_of(r_c, r_k);
                work_re   = 1'b1;
                n_state   = ST_NRM_W;
            end
            ST_NRM_W: begin
                req     = '{start: 1'b1, op: OP_DIV};
                arith_a = r_w_rd;
                n_state = ST_NRM_W_WT;
            end
            ST_NRM_W_WT: begin
                work_addr = addr_of(r_c, r_k);
                if (arith_done) begin
                    w_we    = 1'b1;
                    n_state = ST_NRM_I;
                end
            end
            ST_NRM_I: begin
                req     = '{start: 1'b1, op: OP_DIV};
                arith_a = r_inv_rd;
                n_state = ST_NRM_I_WT;
            end
            ST_NRM_I_WT: begin
                work_addr = addr_of(r_c, r_k);
                if (arith_done) begin
                    inv_we = 1'b1;
                    if (r_k == DW'(DIMENSION - 1)) begin
                        n_r     = '0;
                        n_state = ST_ELIM_SEL;
                    end else begin
                        n_k     = r_k + DW'(1);
                        n_state = ST_NRM_RD;
                    end
                end
            end
            // eliminate the pivot column from every other row
            ST_ELIM_SEL: begin
                if (r_r == r_c) begin
                    if (r_r == DW'(DIMENSION - 1)) begin
                        if (r_c == DW'(DIMENSION - 1)) begin
                            n_state = ST_OUT_RD;
                            n_i     = '0;
                        end else begin
                            n_c     = r_c + DW'(1);
                            n_state = ST_PIV_RD;
                        end
                    end else begin
                        n_r = r_r + DW'(1);
                    end
                end else begin
                    work_addr = addr_of(r_r, r_c);
                    work_re   = 1'b1;
                    n_state   = ST_ELIM_F;
                end
            end
            ST_ELIM_F: begin
                n_k     = '0;
                n_state = ST_ELIM_RD;
            end
            ST_ELIM_RD: begin
                work_addr = addr_of(r_r, r_k);
                work_re   = 1'b1;
                n_state   = ST_ELIM_W;
            end
            ST_ELIM_W: begin
                req     = '{start: 1'b1, op: OP_MULSUB};
                arith_a = r_w_rd;
                arith_b = r_prow_w[r_k];
                n_state = ST_ELIM_W_WT;
            end
            ST_ELIM_W_WT: begin
                if (arith_done) begin
                    w_we    = 1'b1;
                    n_state = ST_ELIM_I;
                end
            end
            ST_ELIM_I: begin
                req     = '{start: 1'b1, op: OP_MULSUB};
                arith_a = r_inv_rd;
                arith_b = r_prow_i[r_k];
                n_state = ST_ELIM_I_WT;
            end
            ST_ELIM_I_WT: begin
                if (arith_done) begin
                    inv_we = 1'b1;
                    if (r_k == DW'(DIMENSION - 1)) begin
                        if (r_r == DW'(DIMENSION - 1)) begin
                            if (r_c == DW'(DIMENSION - 1)) begin
                                n_state = ST_OUT_RD;
                                n_i     = '0;
                            end else begin
                                n_c     = r_c + DW'(1);
                                n_state = ST_PIV_RD;
                            end
                        end else begin
                            n_r     = r_r + DW'(1);
                            n_state = ST_ELIM_SEL;
                        end
                    end else begin
                        n_k     = r_k + DW'(1);
                        n_state = ST_ELIM_RD;
                    end
                end
            end
            // stream the inverse out in row-major order
            ST_OUT_RD: begin
                work_addr = r_i;
                work_re   = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (r_i == AW'(CELLS - 1)) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // singular flag: cleared at compute start, set by any zero pivot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= 1'b0;
        end else if (accept_in && idx_final) begin
            r_zero <= 1'b0;
        end else if (r_state == ST_PIV_CHK && r_w_rd == '0) begin
            r_zero <= 1'b1;
        end
    end

    // pivot, factor and pivot row captures
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PIV_CHK) r_piv <= r_w_rd;
        if (r_state == ST_ELIM_F) r_f <= r_w_rd;
        if (r_state == ST_NRM_W_WT && arith_done) r_prow_w[r_k] <= arith_res;
        if (r_state == ST_NRM_I_WT && arith_done) r_prow_i[r_k] <= arith_res;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (src_we) r_src_mem[src_waddr] <= i_in_data.element_value;
        if (src_re) r_src_rd <= r_src_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_w_mem[work_addr] <= w_wdata;
        if (work_re) r_w_rd <= r_w_mem[work_addr];
    end

    always_ff @(posedge i_clk) begin
        if (inv_we) r_inv_mem[work_addr] <= inv_wdata;
        if (work_re) r_inv_rd <= r_inv_mem[work_addr];
    end

    assign o_out_data.inverse_value = r_inv_rd;
    assign o_out_data.inverse_index = INDEX_W'(r_i);
    assign o_out_data.last_element  = (r_i == AW'(CELLS - 1));
    assign o_out_data.singular      = r_zero;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result offered while accepting input");
    a_start_in_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.start |-> (r_state == ST_NRM_W || r_state == ST_NRM_I ||
                       r_state == ST_ELIM_W || r_state == ST_ELIM_I))
        else $error("arith start outside an issue state");
    a_out_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT_RD)
        else $error("result shown without inverse read");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.last_element |=> r_state == ST_LOAD)
        else $error("last result did not return to load");
`endif

endmodule
`default_nettype wire
